// ----- sv/lfra_pkg.sv -----
// ----------------------------------------------------------------------------
// lfra_pkg
// Shared widths, defaults and register codes for the level fill ring
// animation block.
// ----------------------------------------------------------------------------
package lfra_pkg;

  // Default geometry of the ring and the number of color levels.
  localparam int LED_COUNT_DEF  = 16;
  localparam int NUM_LEVELS_DEF = 8;

  // Fixed field widths.
  localparam int NUM_COLORS  = 8;
  localparam int LVL_W       = 3;
  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Register index of the first level color; colors occupy consecutive indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COLOR_0 = 4'd0;

  typedef logic [COLOR_W-1:0] color_t;

endpackage

// ----- sv/level_fill_ring_animation.sv -----
// A taken tick passes through the input holding register and the pixel counter
// into the output register; the frame then streams one pixel per cycle while
// out_tready is high. The tick rate is set by the pixel counter that walks the
// frame; the next tick is taken while the current frame streams.
// Reset (rst_n low, synchronous): fill count, level and all level colors go
// to zero, and both channels drain empty.
// ----------------------------------------------------------------------------
// level_fill_ring_animation
// Keeps a fill count and a level index that grow with activity and drain when
// idle, and renders each tick as one frame of colored pixels.
// ----------------------------------------------------------------------------
module level_fill_ring_animation #(
  parameter int LED_COUNT  = lfra_pkg::LED_COUNT_DEF,
  parameter int NUM_LEVELS = lfra_pkg::NUM_LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port
  input  logic                               cfg_wr_en,
  input  logic [lfra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfra_pkg::COLOR_W-1:0]       cfg_wdata,
  // Tick input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lfra_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] activity_on, rest zero
  // Pixel output
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lfra_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [5:0] pixel_index,
                                                         // [13:6] red_level,
                                                         // [21:14] green_level,
                                                         // [29:22] blue_level,
                                                         // [31:30] zero
  output logic                               out_tlast   // frame_end
);

  localparam int FILL_W = $clog2(LED_COUNT + 1);
  localparam int CNT_W  = $clog2(LED_COUNT);
  localparam int LVL_W  = lfra_pkg::LVL_W;

  localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(LED_COUNT);
  localparam logic [FILL_W-1:0] FILL_REFILL = FILL_W'(LED_COUNT - 1);
  localparam logic [CNT_W-1:0]  PIX_LAST    = CNT_W'(LED_COUNT - 1);
  localparam logic [LVL_W-1:0]  LVL_TOP     = LVL_W'(NUM_LEVELS - 2);

  // --------------------------------------------------------------------------
  // Level color registers. Writes beyond the color list are dropped.
  // --------------------------------------------------------------------------
  lfra_pkg::color_t color_r [lfra_pkg::NUM_COLORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lfra_pkg::NUM_COLORS; i++) begin
        color_r[i] <= '0;
      end
    end else if (cfg_wr_en &&
                 cfg_index < lfra_pkg::REG_LEVEL_COLOR_0 +
                             lfra_pkg::CFG_IDX_W'(lfra_pkg::NUM_COLORS)) begin
      color_r[LVL_W'(cfg_index - lfra_pkg::REG_LEVEL_COLOR_0)] <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Input holding register. It takes a tick transaction while the previous
  // frame is still streaming, so the next frame starts without a gap.
  // --------------------------------------------------------------------------
  logic pend_vld_r;
  logic pend_act_r;
  logic in_take;
  logic frame_start;

  assign in_tready = !pend_vld_r;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (in_take) begin
      pend_vld_r <= 1'b1;
    end else if (frame_start) begin
      pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_act_r <= in_tdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // Fill and level update, applied when a tick enters the frame generator.
  // Active ticks grow the fill by one and roll over into the next level when
  // full, except at the top level where the ring stays full. Idle ticks drain
  // by up to two and, on empty, refill one short of full a level lower.
  // --------------------------------------------------------------------------
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_step;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [CNT_W-1:0]  split_nxt;

  always_comb begin
    fill_nxt  = fill_r;
    level_nxt = level_r;
    fill_step = fill_r;
    if (pend_act_r) begin
      if (fill_r < FILL_FULL) begin
        fill_step = fill_r + FILL_W'(1);
      end
      fill_nxt = fill_step;
      if (fill_step >= FILL_FULL && level_r < LVL_TOP) begin
        fill_nxt  = '0;
        level_nxt = level_r + LVL_W'(1);
      end
    end else begin
      if (fill_r != '0) begin
        fill_step = fill_r - FILL_W'(1);
      end
      fill_nxt = fill_step;
      if (fill_step != '0) begin
        fill_nxt = fill_step - FILL_W'(1);
      end else if (level_r != '0) begin
        fill_nxt  = FILL_REFILL;
        level_nxt = level_r - LVL_W'(1);
      end
    end
    // The pixel split never passes the last pixel.
    split_nxt = (fill_nxt >= FILL_FULL) ? PIX_LAST : CNT_W'(fill_nxt);
  end

  // --------------------------------------------------------------------------
  // Frame generator: one pixel per cycle into the output register while the output is not stalled.
  // --------------------------------------------------------------------------
  logic              busy_r;
  logic [CNT_W-1:0]  pix_r;
  logic [CNT_W-1:0]  split_r;
  logic [LVL_W-1:0]  cur_lvl_r;
  logic [LVL_W-1:0]  nxt_lvl_r;
  logic              out_adv;
  logic              pix_last;

  assign out_adv     = !out_tvalid || out_tready;
  assign pix_last    = (pix_r == PIX_LAST);
  assign frame_start = pend_vld_r && (!busy_r || (out_adv && pix_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      level_r <= '0;
      busy_r  <= 1'b0;
      pix_r   <= '0;
    end else begin
      if (out_adv && busy_r) begin
        pix_r <= pix_r + CNT_W'(1);
        if (pix_last) begin
          busy_r <= 1'b0;
        end
      end
      if (frame_start) begin
        fill_r  <= fill_nxt;
        level_r <= level_nxt;
        busy_r  <= 1'b1;
        pix_r   <= '0;
      end
    end
  end

  // Frame snapshot of split and level indexes; level colors must stay still while a frame streams (not enforced).
  always_ff @(posedge clk) begin
    if (frame_start) begin
      split_r   <= split_nxt;
      cur_lvl_r <= level_nxt;
      nxt_lvl_r <= level_nxt + LVL_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic                          out_vld_r;
  logic [lfra_pkg::PIX_W-1:0]    out_pix_r;
  lfra_pkg::color_t              out_rgb_r;
  logic                          out_last_r;
  lfra_pkg::color_t              pix_rgb;

  assign pix_rgb = (pix_r <= split_r) ? color_r[nxt_lvl_r] : color_r[cur_lvl_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && busy_r) begin
      out_pix_r  <= lfra_pkg::PIX_W'(pix_r);
      out_rgb_r  <= pix_rgb;
      out_last_r <= pix_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00,
                       out_rgb_r[lfra_pkg::CHAN_W-1:0],
                       out_rgb_r[2*lfra_pkg::CHAN_W-1:lfra_pkg::CHAN_W],
                       out_rgb_r[3*lfra_pkg::CHAN_W-1:2*lfra_pkg::CHAN_W],
                       out_pix_r};

`ifndef SYNTHESIS
  // The fill count never exceeds the ring length.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond ring length");

  // The level never climbs past the second-highest level.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_TOP)
    else $error("level index beyond top level");

  // The frame end flag marks exactly the last pixel position.
  a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_last_r == (out_pix_r == lfra_pkg::PIX_W'(LED_COUNT - 1))))
    else $error("frame end flag on wrong pixel");

  // A taken tick is held until the generator picks it up.
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_vld_r && !frame_start) |=> pend_vld_r)
    else $error("pending tick lost");
`endif

endmodule
